// ===== rtl/snap_points_to_nearest_pad_unit_assert.svh =====
// ----------------------------------------------------------------------------
// snap unit assertion macros
// shared concurrent assertion forms for the nearest pad snap checker
// ----------------------------------------------------------------------------
`ifndef SNAP_POINTS_TO_NEAREST_PAD_UNIT_ASSERT_SVH
`define SNAP_POINTS_TO_NEAREST_PAD_UNIT_ASSERT_SVH

// same-cycle implication
`define SNPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SNPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/snpp_pkg.sv =====
// ----------------------------------------------------------------------------
// snpp_pkg
// types and constants shared by the nearest pad snap unit
// ----------------------------------------------------------------------------
package snpp_pkg;

  localparam int unsigned CoordW         = 32;
  localparam int unsigned TolW           = 24;
  localparam int unsigned SqW            = 2 * TolW;
  localparam int unsigned MaxPadsDefault = 256;

  // item kinds
  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindQuery = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] result_x;
    logic signed [CoordW-1:0] result_y;
    logic                     was_snapped;
    logic                     pads_dropped;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pad_t;

  // one pad presented to the distance unit
  typedef struct packed {
    logic valid;
    pad_t pad;
  } dist_step_t;

endpackage

// ===== rtl/snap_points_to_nearest_pad_unit.sv =====
// ----------------------------------------------------------------------------
// snap_points_to_nearest_pad_unit
// snaps query points to the nearest loaded pad centre within a tolerance
// ----------------------------------------------------------------------------
// load and clear transfers leave the input open; the next item is taken right after
// a query runs from its transfer to a valid result through one full turn of
//   the pad ring (one pad per cycle) plus the pipeline drain
// one query at a time; loads may follow while a result waits on the output
// reset empties the pad count, clears the overflow flag and zeroes tolerance
// pad storage itself is not cleared; entries above the count are never used
module snap_points_to_nearest_pad_unit
  import snpp_pkg::*;
#(
  parameter int unsigned MaxPads = MaxPadsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration write: snap tolerance
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [TolW-1:0] cfg_data_i,
  // item input
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  // result output
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  localparam int unsigned IdxW      = (MaxPads > 1) ? $clog2(MaxPads) : 1;
  localparam int unsigned CntW      = $clog2(MaxPads + 1);
  localparam int unsigned DrainLast = 1;

  // one-hot control states
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StDrain = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // --------------------------------------------------------------------------
  // transfer decode
  // --------------------------------------------------------------------------
  logic in_xfer, is_load, is_query, is_clear;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_load    = in_xfer && (in_data_i.kind == KindLoad);
  assign is_query   = in_xfer && (in_data_i.kind == KindQuery);
  assign is_clear   = in_xfer && (in_data_i.kind == KindClear);

  // --------------------------------------------------------------------------
  // configuration: tolerance and its square, squared once at write time
  // --------------------------------------------------------------------------
  logic [TolW-1:0] tol_q;
  logic [SqW-1:0]  tol_sq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= '0;
      tol_sq_q <= '0;
    end else if (cfg_valid_i) begin
      tol_q    <= cfg_data_i;
      tol_sq_q <= SqW'(cfg_data_i) * SqW'(cfg_data_i);
    end
  end

  // --------------------------------------------------------------------------
  // pad count and overflow flag
  // --------------------------------------------------------------------------
  logic [CntW-1:0] pad_cnt_q;
  logic            overflow_q;
  logic            full;

  assign full = (pad_cnt_q == CntW'(MaxPads));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_cnt_q  <= '0;
      overflow_q <= 1'b0;
    end else if (is_clear) begin
      pad_cnt_q  <= '0;
      overflow_q <= 1'b0;
    end else if (is_load) begin
      if (full) begin
        overflow_q <= 1'b1;
      end else begin
        pad_cnt_q <= pad_cnt_q + CntW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // pad ring: every shift moves each cell toward cell 0
  // a load feeds the new pad in at the tail, so stored pads sit in the top
  // pad_cnt_q cells in load order; a scan feeds cell 0 back to the tail and
  // after MaxPads shifts the ring is back where it started
  // --------------------------------------------------------------------------
  pad_t ring [MaxPads];
  pad_t tail_in;
  pad_t load_pad;
  logic shift_en;

  assign load_pad.x = in_data_i.coord_x;
  assign load_pad.y = in_data_i.coord_y;
  assign shift_en   = (is_load && !full) || (state_q == StScan);
  assign tail_in    = is_load ? load_pad : ring[0];

  for (genvar i = 0; i < MaxPads; i++) begin : g_ring
    pad_t cell_in;
    if (i == MaxPads - 1) begin : g_tail
      assign cell_in = tail_in;
    end else begin : g_body
      assign cell_in = ring[i+1];
    end
    snpp_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_en),
      .pad_i  (cell_in),
      .pad_o  (ring[i])
    );
  end

  // --------------------------------------------------------------------------
  // scan sequencing
  // --------------------------------------------------------------------------
  logic [IdxW-1:0]          tick_q, tick_d;
  logic signed [CoordW-1:0] qx_q, qy_q;
  logic [CntW:0]            tick_sum;
  logic                     scan_valid;
  dist_step_t               step;
  logic                     found;
  pad_t                     best;
  logic                     out_load;

  // head cell at tick t holds stored pad t - (MaxPads - count) when that is >= 0
  assign tick_sum   = (CntW+1)'(tick_q) + (CntW+1)'(pad_cnt_q);
  assign scan_valid = (state_q == StScan) && (tick_sum >= (CntW+1)'(MaxPads));
  assign step.valid = scan_valid;
  assign step.pad   = ring[0];

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      qx_q <= in_data_i.coord_x;
      qy_q <= in_data_i.coord_y;
    end
  end

  snpp_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (is_query),
    .tol_i   (tol_q),
    .tol_sq_i(tol_sq_q),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .step_i  (step),
    .found_o (found),
    .best_o  (best)
  );

  assign out_load = (state_q == StDone) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    unique case (state_q)
      StIdle: begin
        if (is_query) begin
          state_d = StScan;
          tick_d  = '0;
        end
      end
      StScan: begin
        if (tick_q == IdxW'(MaxPads - 1)) begin
          state_d = StDrain;
          tick_d  = '0;
        end else begin
          tick_d = tick_q + IdxW'(1);
        end
      end
      StDrain: begin
        // wait for the last pad to leave the distance pipeline
        if (tick_q == IdxW'(DrainLast)) begin
          state_d = StDone;
        end else begin
          tick_d = tick_q + IdxW'(1);
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tick_q  <= '0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.result_x     <= found ? best.x : qx_q;
      out_data_q.result_y     <= found ? best.y : qy_q;
      out_data_q.was_snapped  <= found;
      out_data_q.pads_dropped <= overflow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/snpp_cell.sv =====
// ----------------------------------------------------------------------------
// snpp_cell
// one stage of the pad ring, holds one pad centre
// ----------------------------------------------------------------------------
module snpp_cell
  import snpp_pkg::*;
(
  input  logic clk_i,
  input  logic shift_i,
  input  pad_t pad_i,
  output pad_t pad_o
);

  pad_t pad_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pad_q <= pad_i;
    end
  end

  assign pad_o = pad_q;

endmodule

// ===== rtl/snpp_dist.sv =====
// ----------------------------------------------------------------------------
// snpp_dist
// three stage squared distance pipeline with running best pad
// ----------------------------------------------------------------------------
module snpp_dist
  import snpp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [TolW-1:0]          tol_i,
  input  logic [SqW-1:0]           tol_sq_i,
  input  logic signed [CoordW-1:0] qx_i,
  input  logic signed [CoordW-1:0] qy_i,
  input  dist_step_t               step_i,
  output logic                     found_o,
  output pad_t                     best_o
);

  // stage 1: absolute differences and range check
  logic signed [CoordW:0] diff_x, diff_y;
  logic [CoordW:0]        abs_x, abs_y;
  logic [CoordW:0]        tol_ext;
  logic                   in_range;

  assign diff_x   = {qx_i[CoordW-1], qx_i} - {step_i.pad.x[CoordW-1], step_i.pad.x};
  assign diff_y   = {qy_i[CoordW-1], qy_i} - {step_i.pad.y[CoordW-1], step_i.pad.y};
  assign abs_x    = diff_x[CoordW] ? (~diff_x + (CoordW+1)'(1)) : diff_x;
  assign abs_y    = diff_y[CoordW] ? (~diff_y + (CoordW+1)'(1)) : diff_y;
  assign tol_ext  = {{(CoordW+1-TolW){1'b0}}, tol_i};
  assign in_range = step_i.valid && (abs_x <= tol_ext) && (abs_y <= tol_ext);

  logic            s1_valid_q;
  logic [TolW-1:0] s1_dx_q, s1_dy_q;
  pad_t            s1_pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q  <= abs_x[TolW-1:0];
    s1_dy_q  <= abs_y[TolW-1:0];
    s1_pad_q <= step_i.pad;
  end

  // stage 2: squares
  logic           s2_valid_q;
  logic [SqW-1:0] s2_sqx_q, s2_sqy_q;
  pad_t           s2_pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sqx_q <= SqW'(s1_dx_q) * SqW'(s1_dx_q);
    s2_sqy_q <= SqW'(s1_dy_q) * SqW'(s1_dy_q);
    s2_pad_q <= s1_pad_q;
  end

  // stage 3: sum and compare, ties go to the later pad
  logic [SqW:0]   d2;
  logic           hit;
  logic [SqW-1:0] best_d2_q;
  logic           found_q;
  pad_t           best_q;

  assign d2  = {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};
  assign hit = s2_valid_q && (d2 <= {1'b0, best_d2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (start_i) begin
      found_q <= 1'b0;
    end else if (hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      best_d2_q <= tol_sq_i;
    end else if (hit) begin
      best_d2_q <= d2[SqW-1:0];
      best_q    <= s2_pad_q;
    end
  end

  assign found_o = found_q;
  assign best_o  = best_q;

endmodule

// ===== rtl/snpp_checker.sv =====
// ----------------------------------------------------------------------------
// snpp_checker
// port level checks for the nearest pad snap unit
// ----------------------------------------------------------------------------
`include "snap_points_to_nearest_pad_unit_assert.svh"

module snpp_checker
  import snpp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic in_xfer;
  logic quick_xfer;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign quick_xfer = in_xfer && (in_data_i.kind != KindQuery);

  // a stalled result holds
  `SNPP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "stalled result changed or dropped")

  // a query occupies the unit
  `SNPP_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_xfer && (in_data_i.kind == KindQuery),
    !in_ready_o, "input still open after query transfer")

  // loads, clears and unknown kinds leave the input open for the next item
  `SNPP_ASSERT_NEXT(a_quick_item, clk_i, rst_ni, quick_xfer,
    in_ready_o, "non-query transfer blocked the input")

  // a new result only appears at the end of a scan
  `SNPP_ASSERT_NOW(a_result_from_scan, clk_i, rst_ni, $rose(out_valid_o),
    $past(!in_ready_o), "result appeared while input was open")

endmodule

bind snap_points_to_nearest_pad_unit snpp_checker u_snpp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
